@@ sv/cqr_pkg.sv @@
// ----------------------------------------------------------------------------
// cqr_pkg
// shared types, codes and helpers for the character queue with remove by value
// ----------------------------------------------------------------------------
package cqr_pkg;

  // operation codes of a request
  localparam logic [1:0] OP_ENQUEUE = 2'd0;
  localparam logic [1:0] OP_REMOVE  = 2'd1;
  localparam logic [1:0] OP_DUMP    = 2'd2;

  // result status codes
  typedef enum logic [2:0] {
    ST_DONE     = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_FULL     = 3'd3,
    ST_ENTRY    = 3'd4
  } status_t;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] value;
  } req_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] entry;
    logic       last;
  } rsp_t;

  // fold ascii lower case letters to upper case, all other bytes unchanged
  function automatic logic [7:0] fold_upper(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h61 && c <= 8'h7A) begin
      r = c - 8'h20;
    end
    return r;
  endfunction

endpackage

@@ sv/cqr_stream_if.sv @@
// ----------------------------------------------------------------------------
// cqr_stream_if
// valid/ready channel carrying one payload struct per request
// ----------------------------------------------------------------------------
interface cqr_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ sv/cqr_ram.sv @@
// ----------------------------------------------------------------------------
// cqr_ram
// generic single-write, single-read synchronous ram, registered read data
// ----------------------------------------------------------------------------
module cqr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/char_queue_remove_by_value.sv @@
// ----------------------------------------------------------------------------
// char_queue_remove_by_value
// ordered byte queue with enqueue, remove-first-match and dump
// ----------------------------------------------------------------------------
// The queue contents sit in one ram of DEPTH bytes, head at address 0, with an
// occupancy counter in flops. Enqueue and every request that answers at once
// (full, empty, unused op code) are finished in the idle state. Remove scans the
// ram from the head with one read a cycle and the compare in the cycle after
// it, up to the first match; it then moves the later entries up one place and
// posts the result. A miss posts not found once the tail has been checked.
// Dump reads one entry and shows it, then reads the next, and waits while the
// result side stalls. Remove and dump are paced by the single ram read port. A
// new request is taken only when the block is idle and the output register is
// free or being emptied in the same cycle.
// ----------------------------------------------------------------------------
module char_queue_remove_by_value
  import cqr_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input logic         clk,
  input logic         rst,
  cqr_stream_if.sink   req,
  cqr_stream_if.source rsp
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OW = $clog2(DEPTH + 1);
  localparam logic [OW-1:0] OCC_FULL = OW'(DEPTH);
  localparam logic [OW-1:0] OCC_ONE  = OW'(1);

  // sequencer states, one-hot
  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SEARCH = 5'b00010,
    S_SHIFT  = 5'b00100,
    S_DUMP   = 5'b01000,
    S_REPLY  = 5'b10000
  } state_t;

  state_t        state, state_next;
  logic [OW-1:0] occ, occ_next;
  logic [OW-1:0] ptr, ptr_next;         // scan / source pointer
  logic          chk_valid, chk_valid_next; // ram data for chk_addr is valid
  logic [AW-1:0] chk_addr, chk_addr_next;
  logic [7:0]    key, key_next;         // folded character to remove
  status_t       reply, reply_next;     // pending status for the reply state

  logic          rsp_valid, rsp_valid_next;
  rsp_t          rsp_data, rsp_data_next;

  // ram port signals
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  logic          out_free;
  logic          accept;
  logic          emit;
  rsp_t          emit_data;
  logic          issue;
  logic [7:0]    req_char;

  cqr_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // output register can take a new result when empty or being drained
  assign out_free  = !rsp_valid || rsp.ready;
  assign req.ready = (state == S_IDLE) && out_free;
  assign accept    = req.valid && req.ready;
  assign req_char  = fold_upper(req.data.value);
  // a further read is due while the pointer is below occupancy
  assign issue     = ptr < occ;

  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_data;

  always_comb begin
    state_next     = state;
    occ_next       = occ;
    ptr_next       = ptr;
    chk_valid_next = chk_valid;
    chk_addr_next  = chk_addr;
    key_next       = key;
    reply_next     = reply;
    emit           = 1'b0;
    emit_data      = '{status: ST_DONE, entry: 8'h00, last: 1'b1};
    ram_we         = 1'b0;
    ram_waddr      = occ[AW-1:0];
    ram_wdata      = req_char;
    ram_raddr      = ptr[AW-1:0];

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (req.data.op)
            OP_ENQUEUE: begin
              emit = 1'b1;
              if (occ == OCC_FULL) begin
                emit_data.status = ST_FULL;
              end else begin
                // append at the tail
                ram_we   = 1'b1;
                occ_next = occ + OCC_ONE;
              end
            end
            OP_REMOVE: begin
              if (occ == '0) begin
                emit             = 1'b1;
                emit_data.status = ST_EMPTY;
              end else begin
                key_next       = req_char;
                ptr_next       = '0;
                chk_valid_next = 1'b0;
                state_next     = S_SEARCH;
              end
            end
            OP_DUMP: begin
              if (occ == '0) begin
                emit             = 1'b1;
                emit_data.status = ST_EMPTY;
              end else begin
                ptr_next       = '0;
                chk_valid_next = 1'b0;
                state_next     = S_DUMP;
              end
            end
            default: begin
              // unused op code, acknowledged with no effect
              emit = 1'b1;
            end
          endcase
        end
      end

      S_SEARCH: begin
        // one read issued per cycle, compare in the next cycle
        chk_valid_next = issue;
        chk_addr_next  = ptr[AW-1:0];
        if (issue) begin
          ptr_next = ptr + OCC_ONE;
        end
        if (chk_valid && ram_rdata == key) begin
          // match: start closing the gap from the entry after it
          ptr_next       = OW'(chk_addr) + OCC_ONE;
          chk_valid_next = 1'b0;
          state_next     = S_SHIFT;
        end else if (chk_valid && (OW'(chk_addr) + OCC_ONE) == occ) begin
          // tail checked without a match
          chk_valid_next = 1'b0;
          reply_next     = ST_NOTFOUND;
          state_next     = S_REPLY;
        end
      end

      S_SHIFT: begin
        // read entry at ptr, write it one place toward the head next cycle
        chk_valid_next = issue;
        chk_addr_next  = ptr[AW-1:0];
        if (issue) begin
          ptr_next = ptr + OCC_ONE;
        end
        if (chk_valid) begin
          ram_we    = 1'b1;
          ram_waddr = chk_addr - AW'(1);
          ram_wdata = ram_rdata;
        end
        if (!issue && !chk_valid) begin
          occ_next   = occ - OCC_ONE;
          reply_next = ST_DONE;
          state_next = S_REPLY;
        end
      end

      S_DUMP: begin
        // read address held on ptr until the entry has been shown
        if (chk_valid) begin
          if (out_free) begin
            emit             = 1'b1;
            emit_data.status = ST_ENTRY;
            emit_data.entry  = ram_rdata;
            emit_data.last   = (ptr + OCC_ONE) == occ;
            chk_valid_next   = 1'b0;
            if ((ptr + OCC_ONE) == occ) begin
              state_next = S_IDLE;
            end else begin
              ptr_next = ptr + OCC_ONE;
            end
          end
        end else begin
          chk_valid_next = 1'b1;
        end
      end

      S_REPLY: begin
        if (out_free) begin
          emit             = 1'b1;
          emit_data.status = reply;
          state_next       = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // output register
  always_comb begin
    rsp_valid_next = rsp_valid;
    rsp_data_next  = rsp_data;
    if (emit) begin
      rsp_valid_next = 1'b1;
      rsp_data_next  = emit_data;
    end else if (rsp.ready) begin
      rsp_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      occ       <= '0;
      chk_valid <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      occ       <= occ_next;
      chk_valid <= chk_valid_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    ptr      <= ptr_next;
    chk_addr <= chk_addr_next;
    key      <= key_next;
    reply    <= reply_next;
    rsp_data <= rsp_data_next;
  end

`ifndef SYNTH
  // occupancy never exceeds the store size
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= OCC_FULL)
    else $error("occupancy above depth");

  // occupancy moves by at most one per cycle
  a_occ_step: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) |-> (occ == $past(occ) || occ == $past(occ) + OCC_ONE ||
                     occ == $past(occ) - OCC_ONE))
    else $error("occupancy jumped");

  // an accepted enqueue with room grows the queue by one
  a_enq_grow: assert property (@(posedge clk) disable iff (rst)
    (accept && req.data.op == OP_ENQUEUE && occ != OCC_FULL)
      |=> occ == $past(occ) + OCC_ONE)
    else $error("enqueue did not append");

  // a new request is never taken while a remove or dump is in progress
  a_busy_block: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !req.ready)
    else $error("request taken while busy");
`endif

endmodule

@@ sim/char_queue_remove_by_value_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// char_queue_remove_by_value_tb
// self-checking bench for the byte queue with enqueue, remove by value, dump
// ----------------------------------------------------------------------------
// A table of directed requests covers the empty and full cases, case folding
// at its boundaries and removal at head, middle and duplicates. Random phases
// follow, some biased to fill the queue and some to drain it. A shadow copy of
// the queue predicts every result, and each result is checked field by field
// in order. Both channels stall at random, except during one calm phase.
// ----------------------------------------------------------------------------
module char_queue_remove_by_value_tb;
  import cqr_pkg::*;

  localparam int QDEPTH = 16;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES = 40;
  localparam int REPORT_MAX = 10;
  localparam int PHASES = 6;
  localparam int PHASE_LEN = 26;
  localparam int CALM_PHASE = 2;

  // op code that the block must ignore
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // one row of the directed table; typed rows carry their own expected status
  typedef struct packed {
    logic [1:0] op;
    logic [7:0] value;
    logic [4:0] rep;
    logic       typed;
    status_t    st;
  } drow_t;

  localparam int NROWS = 18;
  localparam drow_t DIRECTED [0:NROWS-1] = '{
    '{OP_REMOVE,  8'h41, 5'd1,  1'b1, ST_EMPTY},     // remove from empty queue
    '{OP_DUMP,    8'h00, 5'd1,  1'b1, ST_EMPTY},     // dump of empty queue
    '{OP_UNUSED,  8'hFF, 5'd1,  1'b1, ST_DONE},      // unused op code is ignored
    '{OP_ENQUEUE, 8'h61, 5'd1,  1'b1, ST_DONE},      // 'a' folds to 'A'
    '{OP_ENQUEUE, 8'h7A, 5'd1,  1'b1, ST_DONE},      // 'z' folds to 'Z'
    '{OP_ENQUEUE, 8'h60, 5'd1,  1'b1, ST_DONE},      // just below the fold range
    '{OP_ENQUEUE, 8'h7B, 5'd1,  1'b1, ST_DONE},      // just above the fold range
    '{OP_ENQUEUE, 8'h00, 5'd1,  1'b1, ST_DONE},
    '{OP_ENQUEUE, 8'hFF, 5'd1,  1'b1, ST_DONE},
    '{OP_DUMP,    8'h00, 5'd1,  1'b0, ST_DONE},
    '{OP_REMOVE,  8'h71, 5'd1,  1'b1, ST_NOTFOUND},  // no match anywhere
    '{OP_ENQUEUE, 8'h6D, 5'd10, 1'b0, ST_DONE},      // fill up with duplicates
    '{OP_ENQUEUE, 8'h55, 5'd1,  1'b1, ST_FULL},      // enqueue while full
    '{OP_DUMP,    8'h00, 5'd1,  1'b0, ST_DONE},      // full-length dump
    '{OP_REMOVE,  8'h7A, 5'd1,  1'b0, ST_DONE},      // lower case key hits 'Z'
    '{OP_REMOVE,  8'h41, 5'd1,  1'b0, ST_DONE},      // head entry
    '{OP_REMOVE,  8'h6D, 5'd1,  1'b0, ST_DONE},      // first of many duplicates
    '{OP_DUMP,    8'h00, 5'd1,  1'b0, ST_DONE}
  };

  logic clk;
  logic rst;

  cqr_stream_if #(.payload_t(req_t)) req_ch ();
  cqr_stream_if #(.payload_t(rsp_t)) rsp_ch ();

  char_queue_remove_by_value #(
    .DEPTH(QDEPTH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .req(req_ch.sink),
    .rsp(rsp_ch.source)
  );

  // shadow of the queue contents, head at index 0
  logic [7:0] shadow_chars[$];
  // results still owed by the block, oldest first
  rsp_t       owed_results[$];

  // side info that travels with the request on the bus
  logic       cur_typed;
  status_t    cur_st;

  // idling is off while this is set
  bit         calm;

  int n_requests;
  int n_results;
  int n_dumped;
  int n_full;
  int n_hits;
  int n_misses;
  int n_errors;
  int stall_cycles;

  // clock, 8 ns period
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ascii a-z to upper case, everything else untouched
  function automatic logic [7:0] to_upper_ascii(input logic [7:0] c);
    logic [7:0] u;
    u = c;
    if (c >= 8'h61 && c <= 8'h7A) begin
      u = c - 8'h20;
    end
    return u;
  endfunction

  // work out the results of one accepted request and update the shadow queue
  task automatic predict_queue(input req_t r, input logic typed, input status_t typed_st);
    logic [7:0] key;
    rsp_t       one;
    int         hit;
    key = to_upper_ascii(r.value);
    one.status = ST_DONE;
    one.entry = 8'h00;
    one.last = 1'b1;
    hit = -1;
    case (r.op)
      OP_ENQUEUE: begin
        if (shadow_chars.size() >= QDEPTH) begin
          one.status = ST_FULL;
          n_full++;
        end else begin
          shadow_chars.push_back(key);
        end
      end
      OP_REMOVE: begin
        if (shadow_chars.size() == 0) begin
          one.status = ST_EMPTY;
        end else begin
          for (int i = 0; i < shadow_chars.size(); i++) begin
            if (hit < 0 && shadow_chars[i] == key) hit = i;
          end
          if (hit < 0) begin
            one.status = ST_NOTFOUND;
            n_misses++;
          end else begin
            // later entries close the gap in order
            shadow_chars.delete(hit);
            n_hits++;
          end
        end
      end
      OP_DUMP: begin
        if (shadow_chars.size() == 0) begin
          one.status = ST_EMPTY;
        end
      end
      default: begin
        // ignored request, plain done
      end
    endcase
    if (r.op == OP_DUMP && shadow_chars.size() != 0) begin
      // one result per entry, head first, last flag on the tail only
      for (int i = 0; i < shadow_chars.size(); i++) begin
        one.status = ST_ENTRY;
        one.entry = shadow_chars[i];
        one.last = (i == shadow_chars.size() - 1);
        owed_results.push_back(one);
      end
    end else if (typed) begin
      one.status = typed_st;
      one.entry = 8'h00;
      one.last = 1'b1;
      owed_results.push_back(one);
    end else begin
      owed_results.push_back(one);
    end
  endtask

  // present one request, entered and left at a falling edge
  task automatic send_request(input logic [1:0] op, input logic [7:0] value,
                              input logic typed, input status_t typed_st);
    // random gap before the request
    while (!calm && $urandom_range(99) < 6) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data.op <= op;
    req_ch.data.value <= value;
    cur_typed <= typed;
    cur_st <= typed_st;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // random key: mostly a small letter set so that removes hit and duplicates form
  function automatic logic [7:0] pick_key(input bit from_queue);
    logic [7:0] c;
    int         roll;
    roll = $urandom_range(99);
    if (from_queue && shadow_chars.size() != 0) begin
      c = shadow_chars[$urandom_range(shadow_chars.size() - 1)];
    end else if (roll < 55) begin
      c = 8'h41 + 8'($urandom_range(7));
    end else if (roll < 70) begin
      c = 8'h41 + 8'($urandom_range(25));
    end else begin
      c = 8'($urandom_range(255));
    end
    // stored letters are upper case, ask for them in lower case half the time
    if (c >= 8'h41 && c <= 8'h5A && $urandom_range(1) == 1) begin
      c = c + 8'h20;
    end
    return c;
  endfunction

  // result side: random back-pressure
  always @(negedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 6);
    end
  end

  // monitor: predicts on each accepted request, checks each accepted result
  always @(posedge clk) begin
    rsp_t want;
    bit   moved;
    if (!rst) begin
      moved = 1'b0;
      if (rsp_ch.valid && rsp_ch.ready) begin
        moved = 1'b1;
        n_results++;
        if (rsp_ch.data.status == ST_ENTRY) n_dumped++;
        if (owed_results.size() == 0) begin
          n_errors++;
          if (n_errors <= REPORT_MAX) begin
            $display("unexpected result: status %0d entry %02h last %0b",
                     rsp_ch.data.status, rsp_ch.data.entry, rsp_ch.data.last);
          end
        end else begin
          want = owed_results.pop_front();
          if (rsp_ch.data.status !== want.status || rsp_ch.data.entry !== want.entry ||
              rsp_ch.data.last !== want.last) begin
            n_errors++;
            if (n_errors <= REPORT_MAX) begin
              $display("result mismatch: expected status %0d entry %02h last %0b,",
                       want.status, want.entry, want.last,
                       " got status %0d entry %02h last %0b",
                       rsp_ch.data.status, rsp_ch.data.entry, rsp_ch.data.last);
            end
          end
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        moved = 1'b1;
        n_requests++;
        predict_queue(req_ch.data, cur_typed, cur_st);
      end
      // watchdog on cycles without any handshake
      if (moved) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    int         enq_pct;
    int         rem_pct;
    int         roll;
    logic [1:0] op;
    logic [7:0] value;
    rst = 1'b1;
    calm = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    cur_typed = 1'b0;
    cur_st = ST_DONE;
    n_requests = 0;
    n_results = 0;
    n_dumped = 0;
    n_full = 0;
    n_hits = 0;
    n_misses = 0;
    n_errors = 0;
    stall_cycles = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed table
    for (int r = 0; r < NROWS; r++) begin
      for (int k = 0; k < DIRECTED[r].rep; k++) begin
        send_request(DIRECTED[r].op, DIRECTED[r].value, DIRECTED[r].typed, DIRECTED[r].st);
      end
    end

    // random phases, alternating between filling and draining the queue
    for (int p = 0; p < PHASES; p++) begin
      calm = (p == CALM_PHASE);
      enq_pct = (p % 2 == 0) ? 65 : 30;
      rem_pct = (p % 2 == 0) ? 20 : 55;
      for (int n = 0; n < PHASE_LEN; n++) begin
        roll = $urandom_range(99);
        if (roll < enq_pct) begin
          op = OP_ENQUEUE;
          value = pick_key(1'b0);
        end else if (roll < enq_pct + rem_pct) begin
          op = OP_REMOVE;
          // most removes aim at a char that is really there
          value = pick_key($urandom_range(99) < 65);
        end else if (roll < 95) begin
          op = OP_DUMP;
          value = 8'($urandom_range(255));
        end else begin
          op = OP_UNUSED;
          value = 8'($urandom_range(255));
        end
        send_request(op, value, 1'b0, ST_DONE);
      end
    end
    calm = 1'b0;
    req_ch.valid <= 1'b0;

    // drain, then let the block settle
    while (owed_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (owed_results.size() != 0) begin
      $display("%0d results never arrived", owed_results.size());
    end
    $display("covered %0d requests and %0d results, %0d of them dumped chars",
             n_requests, n_results, n_dumped);
    $display("removes: %0d hits, %0d misses; %0d enqueues refused as full; %0d mismatches",
             n_hits, n_misses, n_full, n_errors);
    if (n_errors == 0 && owed_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
